FILE: rtl/core/dedup_bounded_fifo_burst_drain_top_macros.svh
// Assertion macros shared by the queue RTL; clocked on clk, disabled while rst_n is low.
`ifndef DEDUP_BOUNDED_FIFO_BURST_DRAIN_TOP_MACROS_SVH
`define DEDUP_BOUNDED_FIFO_BURST_DRAIN_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge.
`define DBFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define DBFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DBFD_ASSERT(lbl, prop, msg)
`define DBFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/dbfd_pkg.sv
// Shared types, codes and constants of the deduplicating placement queue.
`default_nettype none

package dbfd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_POPS        = 16;
    localparam int CFG_W           = 5;
    localparam int CFG_IDX_W       = 1;
    localparam int CMD_W           = 2;
    localparam int GRID_W          = 8;
    localparam int CELL_W          = 32;
    localparam int ROT_W           = 8;
    localparam int STATUS_W        = 3;

    // Command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POPS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE   = 2'd0,
        CMD_POP_FRAME = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_NONE      = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        OP_ENQUEUE,
        OP_REJECT,
        OP_POP,
        OP_CLEAR
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_INVALID   = 3'd3,
        ST_POPPED    = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_POP
    } back_state_t;

    // Classified request passed from front to back
    typedef struct packed {
        op_t                      op;
        logic [GRID_W-1:0]        grid;
        logic [CELL_W-1:0]        cell_id;
        logic signed [ROT_W-1:0]  rot;
    } req_t;

    // One queued placement request
    typedef struct packed {
        logic [GRID_W-1:0]        grid;
        logic [CELL_W-1:0]        cell_id;
        logic signed [ROT_W-1:0]  rot;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/dbfd_front.sv
// Front end: command handshake and request classification.
`default_nettype none

module dbfd_front
    import dbfd_pkg::*;
(
    input  logic                     start,
    input  logic [CMD_W-1:0]         command,
    input  logic                     grid_valid,
    input  logic [GRID_W-1:0]        grid_handle,
    input  logic [CELL_W-1:0]        cell_key,
    input  logic signed [ROT_W-1:0]  rotation_steps,
    input  logic                     q_full,
    output logic                     busy,
    output logic                     push,
    output req_t                     push_req
);

    logic accept;

    // Take a command whenever the command queue has room
    assign busy   = q_full;
    assign accept = start && !q_full;

    // Classify; unknown commands are consumed and dropped here
    always_comb
    begin
        push             = 1'b0;
        push_req.op      = OP_CLEAR;
        push_req.grid    = grid_handle;
        push_req.cell_id = cell_key;
        push_req.rot     = rotation_steps;
        case (command_t'(command))
            CMD_ENQUEUE:
            begin
                push        = accept;
                push_req.op = grid_valid ? OP_ENQUEUE : OP_REJECT;
            end
            CMD_POP_FRAME:
            begin
                push        = accept;
                push_req.op = OP_POP;
            end
            CMD_CLEAR:
            begin
                push        = accept;
                push_req.op = OP_CLEAR;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/dbfd_queue.sv
// Short command queue decoupling the front end from the back end.
`default_nettype none

module dbfd_queue
    import dbfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_req,
    input  logic pop,
    output logic full,
    output logic empty,
    output req_t head
);

`include "dedup_bounded_fifo_burst_drain_top_macros.svh"

    req_t                slot_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_next;
    logic [CQ_CNT_W-1:0] fill_reg;
    logic [CQ_CNT_W-1:0] fill_next;

    function automatic logic [CQ_PTR_W-1:0] ptr_inc(input logic [CQ_PTR_W-1:0] p);
        return (p == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (fill_reg == CQ_CNT_W'(CQ_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Request storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

    `DBFD_ASSERT(a_cq_no_overflow, !(push && full && !pop), "command queue overflow")
    `DBFD_ASSERT(a_cq_no_underflow, !(pop && empty), "command queue underflow")

endmodule

`default_nettype wire

FILE: rtl/core/dbfd_back.sv
// Back end: entry store, duplicate search, drop-oldest enqueue and burst drain.
`default_nettype none

module dbfd_back
    import dbfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     q_empty,
    input  req_t                     q_head,
    output logic                     q_pop,
    output logic                     result_valid,
    output logic [STATUS_W-1:0]      status,
    output logic [GRID_W-1:0]        out_grid,
    output logic [CELL_W-1:0]        out_cell,
    output logic signed [ROT_W-1:0]  out_rotation,
    output logic [CFG_W-1:0]         dropped_count,
    output logic                     last
);

`include "dedup_bounded_fifo_burst_drain_top_macros.svh"

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SUM_W = LIM_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S    = SUM_W'(QUEUE_DEPTH);
    localparam logic [LIM_W-1:0] DEPTH_L    = LIM_W'(QUEUE_DEPTH);
    localparam logic [CFG_W-1:0] MAX_POPS_C = CFG_W'(MAX_POPS);
    localparam logic [CFG_W-1:0] DROP_SAT   = '1;

    // Entry store (no reset: only occupied slots are ever read)
    entry_t                   entry_store_reg [QUEUE_DEPTH];

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [IDX_W-1:0]         head_reg;
    logic [IDX_W-1:0]         head_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CFG_W-1:0]         pop_left_reg;
    logic [CFG_W-1:0]         pop_left_next;
    logic [CFG_W-1:0]         pops_cfg_reg;
    logic [CFG_W-1:0]         pops_cfg_next;
    logic [CFG_W-1:0]         limit_cfg_reg;
    logic [CFG_W-1:0]         limit_cfg_next;

    logic                     result_valid_reg;
    logic                     result_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [GRID_W-1:0]        out_grid_reg;
    logic [GRID_W-1:0]        out_grid_next;
    logic [CELL_W-1:0]        out_cell_reg;
    logic [CELL_W-1:0]        out_cell_next;
    logic signed [ROT_W-1:0]  out_rotation_reg;
    logic signed [ROT_W-1:0]  out_rotation_next;
    logic [CFG_W-1:0]         dropped_reg;
    logic [CFG_W-1:0]         dropped_next;
    logic                     last_reg;
    logic                     last_next;

    logic                     wr_en;
    logic [IDX_W-1:0]         tail_idx;
    logic [LIM_W-1:0]         count_l;
    logic [LIM_W-1:0]         limit_raw;
    logic [LIM_W-1:0]         eff_limit;
    logic                     at_limit;
    logic [LIM_W-1:0]         drop_l;
    logic [CFG_W-1:0]         drop_sat;
    logic [CFG_W-1:0]         budget_raw;
    logic [CFG_W-1:0]         budget;
    logic [CFG_W-1:0]         n_pop;
    logic [QUEUE_DEPTH-1:0]   hit;
    logic                     dup;
    entry_t                   head_entry;

    // (base + step) modulo depth; step never exceeds the depth
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [LIM_W-1:0] step);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(step);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Effective limits, drop count and burst length
    always_comb
    begin
        count_l    = LIM_W'(count_reg);
        limit_raw  = (limit_cfg_reg == '0) ? LIM_W'(1) : LIM_W'(limit_cfg_reg);
        eff_limit  = (limit_raw > DEPTH_L) ? DEPTH_L : limit_raw;
        at_limit   = (count_l >= eff_limit);
        drop_l     = count_l - eff_limit + LIM_W'(1);
        drop_sat   = (drop_l > LIM_W'(DROP_SAT)) ? DROP_SAT : drop_l[CFG_W-1:0];
        budget_raw = (pops_cfg_reg == '0) ? CFG_W'(1) : pops_cfg_reg;
        budget     = (budget_raw > MAX_POPS_C) ? MAX_POPS_C : budget_raw;
        n_pop      = (count_l < LIM_W'(budget)) ? count_l[CFG_W-1:0] : budget;
        tail_idx   = wrap_add(head_reg, count_l);
        head_entry = entry_store_reg[head_reg];
    end

    // Parallel duplicate search over occupied slots
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            logic [LIM_W-1:0] offset;
            offset = (LIM_W'(i) >= LIM_W'(head_reg)) ?
                     LIM_W'(i) - LIM_W'(head_reg) :
                     LIM_W'(i) + DEPTH_L - LIM_W'(head_reg);
            hit[i] = (offset < count_l) &&
                     (entry_store_reg[i].grid == q_head.grid) &&
                     (entry_store_reg[i].cell_id == q_head.cell_id);
        end
        dup = |hit;
    end

    // Configuration writes
    always_comb
    begin
        pops_cfg_next  = pops_cfg_reg;
        limit_cfg_next = limit_cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_POPS:  pops_cfg_next  = cfg_data;
                CFG_IDX_LIMIT: limit_cfg_next = cfg_data;
                default:       pops_cfg_next  = pops_cfg_reg;
            endcase
        end
    end

    // Execution FSM: non-burst commands are executed in idle, one entry per cycle in a burst
    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        pop_left_next     = pop_left_reg;
        q_pop             = 1'b0;
        wr_en             = 1'b0;
        result_valid_next = 1'b0;
        status_next       = ST_QUEUED;
        out_grid_next     = '0;
        out_cell_next     = '0;
        out_rotation_next = '0;
        dropped_next      = '0;
        last_next         = 1'b1;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        OP_REJECT:
                        begin
                            result_valid_next = 1'b1;
                            status_next       = ST_INVALID;
                        end
                        OP_ENQUEUE:
                        begin
                            result_valid_next = 1'b1;
                            if (dup)
                            begin
                                status_next = ST_DUPLICATE;
                            end
                            else
                            begin
                                // Tail slot is head + count whether or not we drop
                                wr_en = 1'b1;
                                if (at_limit)
                                begin
                                    head_next    = wrap_add(head_reg, drop_l);
                                    count_next   = eff_limit[CNT_W-1:0];
                                    status_next  = ST_DROPPED;
                                    dropped_next = drop_sat;
                                end
                                else
                                begin
                                    count_next  = count_reg + 1'b1;
                                    status_next = ST_QUEUED;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                result_valid_next = 1'b1;
                                status_next       = ST_EMPTY;
                            end
                            else
                            begin
                                pop_left_next = n_pop;
                                state_next    = BK_POP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            result_valid_next = 1'b1;
                            status_next       = ST_CLEARED;
                            head_next         = '0;
                            count_next        = '0;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_POP:
            begin
                result_valid_next = 1'b1;
                status_next       = ST_POPPED;
                out_grid_next     = head_entry.grid;
                out_cell_next     = head_entry.cell_id;
                out_rotation_next = head_entry.rot;
                last_next         = (pop_left_reg == CFG_W'(1));
                head_next         = wrap_add(head_reg, LIM_W'(1));
                count_next        = count_reg - 1'b1;
                pop_left_next     = pop_left_reg - 1'b1;
                if (pop_left_reg == CFG_W'(1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            head_reg         <= '0;
            count_reg        <= '0;
            pop_left_reg     <= '0;
            pops_cfg_reg     <= CFG_W'(1);
            limit_cfg_reg    <= CFG_W'(16);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            pop_left_reg     <= pop_left_next;
            pops_cfg_reg     <= pops_cfg_next;
            limit_cfg_reg    <= limit_cfg_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        out_grid_reg     <= out_grid_next;
        out_cell_reg     <= out_cell_next;
        out_rotation_reg <= out_rotation_next;
        dropped_reg      <= dropped_next;
        last_reg         <= last_next;
    end

    // Entry store write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_store_reg[tail_idx] <= '{grid: q_head.grid, cell_id: q_head.cell_id,
                                           rot: q_head.rot};
        end
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign out_grid      = out_grid_reg;
    assign out_cell      = out_cell_reg;
    assign out_rotation  = out_rotation_reg;
    assign dropped_count = dropped_reg;
    assign last          = last_reg;

    `DBFD_ASSERT(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
    `DBFD_ASSERT(a_burst_covered, (state_reg != BK_POP) || ((pop_left_reg != '0) && (LIM_W'(pop_left_reg) <= count_l)), "burst longer than occupancy")
    `DBFD_ASSERT_NEXT(a_burst_end, (state_reg == BK_POP) && (pop_left_reg == CFG_W'(1)), result_valid_reg && last_reg && (state_reg == BK_IDLE), "burst did not end with last")

endmodule

`default_nettype wire

FILE: rtl/core/dedup_bounded_fifo_burst_drain_top.sv
// Enqueue, clear, reject and empty pop give their result from the result registers once the
// back end takes them from the command queue; a pop frame that finds entries first enters the pop state.
// Enqueue, clear and reject are executed by the back end in idle; a pop frame of n entries takes
// one setup step in idle, then one entry per cycle from the single store read port.
// A two-entry command queue keeps start open while a burst drains; busy is high when it is full.
// Results are a one-cycle strobe with no stall. Reset clears the queue to empty, budget 1,
// limit 16; the entry store itself is not cleared and needs no clearing pass.
`default_nettype none

module dedup_bounded_fifo_burst_drain_top
    import dbfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         command,
    input  logic                     grid_valid,
    input  logic [GRID_W-1:0]        grid_handle,
    input  logic [CELL_W-1:0]        cell_key,
    input  logic signed [ROT_W-1:0]  rotation_steps,
    output logic                     result_valid,
    output logic [STATUS_W-1:0]      status,
    output logic [GRID_W-1:0]        out_grid,
    output logic [CELL_W-1:0]        out_cell,
    output logic signed [ROT_W-1:0]  out_rotation,
    output logic [CFG_W-1:0]         dropped_count,
    output logic                     last,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    req_t push_req;
    req_t q_head;

    // Front end: handshake and classification
    dbfd_front u_front (
        .start          (start),
        .command        (command),
        .grid_valid     (grid_valid),
        .grid_handle    (grid_handle),
        .cell_key       (cell_key),
        .rotation_steps (rotation_steps),
        .q_full         (q_full),
        .busy           (busy),
        .push           (q_push),
        .push_req       (push_req)
    );

    // Command queue
    dbfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (push_req),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Back end: store and execution
    dbfd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .status        (status),
        .out_grid      (out_grid),
        .out_cell      (out_cell),
        .out_rotation  (out_rotation),
        .dropped_count (dropped_count),
        .last          (last)
    );

endmodule

`default_nettype wire
